>>> sv/assert_macros.svh
// assertion macros used by the deframer core module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfd assertion failed");

// next-cycle implication, disabled in reset
`define PFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfd assertion failed");

`endif

>>> sv/pfd_pkg.sv
// package: constants and types of the pose frame deframer
`timescale 1ns / 1ps

package pfd_pkg;

    localparam int PAYLOAD_LEN = 24;
    localparam int WORD_COUNT  = 6;
    localparam int CNT_W       = $clog2(PAYLOAD_LEN);
    localparam int ADDR_W      = 3;

    typedef logic [7:0]  byte_t;
    typedef logic [31:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam byte_t HDR_FIRST  = 8'h0D;
    localparam byte_t HDR_SECOND = 8'h0A;
    localparam cnt_t  LAST_INDEX = CNT_W'(PAYLOAD_LEN - 1);

    localparam logic [ADDR_W-1:0] ADDR_INVERT = ADDR_W'(0);

    localparam word_t SIGN_BIT = 32'h8000_0000;

    typedef enum logic [4:0] {
        ST_HUNT    = 5'b00001,
        ST_HDR2    = 5'b00010,
        ST_PAYLOAD = 5'b00100,
        ST_TRL1    = 5'b01000,
        ST_TRL2    = 5'b10000
    } state_t;

    typedef struct packed {
        logic shift_en;
        logic frame_done;
        logic in_trl2;
    } pfd_ctrl_t;

endpackage

>>> sv/pfd_byte_cell.sv
// one byte cell of the payload shift chain
`timescale 1ns / 1ps

module pfd_byte_cell (
    input  logic          clk,
    input  logic          shift_en,
    input  pfd_pkg::byte_t din,
    output pfd_pkg::byte_t dout
);
    import pfd_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    always_comb
    begin
        data_next = shift_en ? din : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign dout = data_reg;

endmodule

>>> sv/pfd_frame_ctrl.sv
// frame state machine: header, payload count and trailer checks
`timescale 1ns / 1ps

module pfd_frame_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pfd_pkg::byte_t     rx_byte,
    output pfd_pkg::pfd_ctrl_t ctrl
);
    import pfd_pkg::*;

    state_t state_reg;
    state_t state_next;
    cnt_t   cnt_reg;
    cnt_t   cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            case (state_reg)
                ST_HUNT:
                begin
                    state_next = (rx_byte == HDR_FIRST) ? ST_HDR2 : ST_HUNT;
                end
                ST_HDR2:
                begin
                    if (rx_byte == HDR_SECOND)
                    begin
                        state_next = ST_PAYLOAD;
                        cnt_next   = '0;
                    end
                    else if (rx_byte != HDR_FIRST)
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_PAYLOAD:
                begin
                    if (cnt_reg == LAST_INDEX)
                    begin
                        state_next = ST_TRL1;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                ST_TRL1:
                begin
                    state_next = (rx_byte == HDR_SECOND) ? ST_TRL2 : ST_HUNT;
                end
                ST_TRL2:
                begin
                    state_next = ST_HUNT;
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        ctrl.shift_en   = accept && (state_reg == ST_PAYLOAD);
        ctrl.frame_done = accept && (state_reg == ST_TRL2) && (rx_byte == HDR_FIRST);
        ctrl.in_trl2    = (state_reg == ST_TRL2);
    end

endmodule

>>> sv/pose_frame_deframer_core.sv
// top level: pose frame deframer with payload cell chain and output register
`timescale 1ns / 1ps

// Takes received bytes and finds frames of 0x0D 0x0A, 24 payload bytes, 0x0A
// 0x0D (extra 0x0D bytes in the header are skipped). A byte can be accepted
// every cycle that in_stall is low; the payload moves through a chain of 24
// byte cells; at the edge accepting the closing 0x0D the six little-endian
// words, plus the two position copies with optional sign flip, load the
// output register, so out_valid rises in the next cycle. in_stall is raised
// only while the parser waits for the closing 0x0D and the previous word
// still waits on out_stall. Register 0 (address 0) bit 0 is invert_position.

`include "assert_macros.svh"

module pose_frame_deframer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pfd_pkg::byte_t              rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pfd_pkg::word_t              z_angle,
    output pfd_pkg::word_t              x_angle,
    output pfd_pkg::word_t              y_angle,
    output pfd_pkg::word_t              x_position,
    output pfd_pkg::word_t              y_position,
    output pfd_pkg::word_t              z_rate,
    output pfd_pkg::word_t              x_position_adjusted,
    output pfd_pkg::word_t              y_position_adjusted
);
    import pfd_pkg::*;

    logic      invert_reg;
    logic      invert_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      accept;
    pfd_ctrl_t ctrl;
    byte_t     chain [PAYLOAD_LEN+1];
    word_t     words [WORD_COUNT];
    word_t     flip;
    word_t     out_reg [WORD_COUNT+2];

    // config port
    assign pready = 1'b1;

    always_comb
    begin
        invert_next = invert_reg;
        if (psel && penable && pwrite && (paddr == ADDR_INVERT))
        begin
            invert_next = pwdata[0];
        end
        prdata = (paddr == ADDR_INVERT) ? {31'b0, invert_reg} : '0;
    end

    // input side
    assign in_stall = out_valid_reg && out_stall && ctrl.in_trl2;
    assign accept   = in_valid && !in_stall;

    pfd_frame_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .ctrl    (ctrl)
    );

    // payload chain, new bytes enter at the top and move toward cell 0
    assign chain[PAYLOAD_LEN] = rx_byte;

    for (genvar i = 0; i < PAYLOAD_LEN; i++)
    begin : g_cell
        pfd_byte_cell u_cell (
            .clk      (clk),
            .shift_en (ctrl.shift_en),
            .din      (chain[i+1]),
            .dout     (chain[i])
        );
    end

    for (genvar w = 0; w < WORD_COUNT; w++)
    begin : g_word
        assign words[w] = {chain[4*w+3], chain[4*w+2], chain[4*w+1], chain[4*w]};
    end

    assign flip = invert_reg ? SIGN_BIT : '0;

    // output register
    always_comb
    begin
        out_valid_next = ctrl.frame_done ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.frame_done)
        begin
            for (int k = 0; k < WORD_COUNT; k++)
            begin
                out_reg[k] <= words[k];
            end
            out_reg[WORD_COUNT]   <= words[3] ^ flip;
            out_reg[WORD_COUNT+1] <= words[4] ^ flip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            invert_reg    <= invert_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign z_angle             = out_reg[0];
    assign x_angle             = out_reg[1];
    assign y_angle             = out_reg[2];
    assign x_position          = out_reg[3];
    assign y_position          = out_reg[4];
    assign z_rate              = out_reg[5];
    assign x_position_adjusted = out_reg[WORD_COUNT];
    assign y_position_adjusted = out_reg[WORD_COUNT+1];

    `PFD_ASSERT_IMPL(a_no_overwrite, ctrl.frame_done, !(out_valid_reg && out_stall))
    `PFD_ASSERT_NEXT(a_done_valid, ctrl.frame_done, out_valid_reg)
    `PFD_ASSERT_IMPL(a_no_shift_at_done, ctrl.shift_en, !ctrl.frame_done)
    `PFD_ASSERT_NEXT(a_adjust, ctrl.frame_done && !(psel && penable && pwrite),
        (x_position_adjusted ^ x_position) == (invert_reg ? SIGN_BIT : 32'h0))

endmodule

>>> tb/sv/pose_frame_deframer_core_tb.sv
// testbench: pose frame deframer core, byte stream against a frame predictor
`timescale 1ns / 1ps

module pose_frame_deframer_core_tb;

    import pfd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_LEN      = 300;
    localparam int N_DIR         = 10;
    localparam int N_TRAFFIC     = 4;
    localparam int MAX_REPORTS   = 10;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR2,
        PH_BODY,
        PH_TRL1,
        PH_TRL2
    } parse_phase_t;

    typedef struct packed {
        word_t z_angle;
        word_t x_angle;
        word_t y_angle;
        word_t x_position;
        word_t y_position;
        word_t z_rate;
        word_t x_position_adjusted;
        word_t y_position_adjusted;
    } pose_t;

    typedef struct {
        int    n_cr;
        byte_t hdr2;
        byte_t fill;
        bit    ramp;
        byte_t trl1;
        byte_t trl2;
        bit    inv;
        bit    typed;
        word_t exp_word;
        word_t exp_adj;
    } frame_recipe_t;

    typedef struct {
        int          send_pct;
        int          recv_pct;
        logic [31:0] cfg;
    } traffic_phase_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    byte_t             rx_byte;
    logic              out_valid;
    logic              out_stall;
    word_t             z_angle;
    word_t             x_angle;
    word_t             y_angle;
    word_t             x_position;
    word_t             y_position;
    word_t             z_rate;
    word_t             x_position_adjusted;
    word_t             y_position_adjusted;

    pose_t        pending_frames [$];
    parse_phase_t parse_phase;
    logic [4:0]   body_idx;
    byte_t        body_buf [PAYLOAD_LEN];
    bit           invert_cfg;
    bit           use_typed;
    pose_t        typed_frame;
    int           mismatches;
    int           bytes_sent;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         hold_go;
    int           hold_left;

    frame_recipe_t dir_rows [0:N_DIR-1] = '{
        '{0, HDR_SECOND, 8'h00, 1'b0, HDR_SECOND, HDR_FIRST, 1'b0, 1'b1,
          32'h0000_0000, 32'h0000_0000},
        '{0, HDR_SECOND, 8'hFF, 1'b0, HDR_SECOND, HDR_FIRST, 1'b0, 1'b1,
          32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{3, HDR_SECOND, 8'h00, 1'b1, HDR_SECOND, HDR_FIRST, 1'b0, 1'b0, '0, '0},
        '{0, 8'h55,      8'h00, 1'b1, HDR_SECOND, HDR_FIRST, 1'b0, 1'b0, '0, '0},
        '{0, HDR_SECOND, 8'h0A, 1'b1, HDR_FIRST,  HDR_SECOND, 1'b0, 1'b0, '0, '0},
        '{0, HDR_SECOND, 8'h0D, 1'b0, HDR_SECOND, HDR_SECOND, 1'b0, 1'b0, '0, '0},
        '{1, HDR_SECOND, 8'h0A, 1'b0, HDR_SECOND, HDR_FIRST, 1'b0, 1'b0, '0, '0},
        '{0, HDR_SECOND, 8'hFF, 1'b0, HDR_SECOND, HDR_FIRST, 1'b1, 1'b1,
          32'hFFFF_FFFF, 32'h7FFF_FFFF},
        '{0, HDR_SECOND, 8'h00, 1'b0, HDR_SECOND, HDR_FIRST, 1'b1, 1'b1,
          32'h0000_0000, 32'h8000_0000},
        '{0, HDR_SECOND, 8'h80, 1'b1, HDR_SECOND, HDR_FIRST, 1'b1, 1'b0, '0, '0}
    };

    traffic_phase_t traffic [0:N_TRAFFIC-1] = '{
        '{0,  0,  32'hFFFF_FFFF},
        '{79, 0,  32'h0000_0000},
        '{0,  79, 32'h0000_0001},
        '{30, 30, 32'hFFFF_FFFE}
    };

    pose_frame_deframer_core dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .z_angle             (z_angle),
        .x_angle             (x_angle),
        .y_angle             (y_angle),
        .x_position          (x_position),
        .y_position          (y_position),
        .z_rate              (z_rate),
        .x_position_adjusted (x_position_adjusted),
        .y_position_adjusted (y_position_adjusted)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic parse_byte(input byte_t b, output bit done, output pose_t res);
        word_t w [WORD_COUNT];
        word_t flip;
        done = 1'b0;
        res  = '0;
        case (parse_phase)
            PH_HUNT:
                parse_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
            PH_HDR2:
            begin
                if (b == HDR_SECOND)
                begin
                    body_idx    = '0;
                    parse_phase = PH_BODY;
                end
                else if (b != HDR_FIRST)
                begin
                    parse_phase = PH_HUNT;
                end
            end
            PH_BODY:
            begin
                if (body_idx < PAYLOAD_LEN)
                begin
                    body_buf[body_idx] = b;
                    body_idx = body_idx + 5'd1;
                end
                if (body_idx >= PAYLOAD_LEN)
                begin
                    body_idx    = '0;
                    parse_phase = PH_TRL1;
                end
            end
            PH_TRL1:
                parse_phase = (b == HDR_SECOND) ? PH_TRL2 : PH_HUNT;
            PH_TRL2:
            begin
                parse_phase = PH_HUNT;
                if (b == HDR_FIRST)
                begin
                    for (int k = 0; k < WORD_COUNT; k++)
                    begin
                        w[k] = {body_buf[4*k+3], body_buf[4*k+2],
                                body_buf[4*k+1], body_buf[4*k]};
                    end
                    flip = invert_cfg ? SIGN_BIT : '0;
                    res.z_angle             = w[0];
                    res.x_angle             = w[1];
                    res.y_angle             = w[2];
                    res.x_position          = w[3];
                    res.y_position          = w[4];
                    res.z_rate              = w[5];
                    res.x_position_adjusted = w[3] ^ flip;
                    res.y_position_adjusted = w[4] ^ flip;
                    done = 1'b1;
                end
            end
            default:
                parse_phase = PH_HUNT;
        endcase
    endtask

    task automatic send_byte(input byte_t b);
        bit    done;
        pose_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, done, res);
        if (done)
            pending_frames.push_back(use_typed ? typed_frame : res);
        bytes_sent++;
    endtask

    task automatic send_frame(input int n_cr, input byte_t h1, input byte_t h2,
                              input byte_t pl [PAYLOAD_LEN],
                              input byte_t t1, input byte_t t2);
        send_byte(h1);
        repeat (n_cr)
            send_byte(HDR_FIRST);
        send_byte(h2);
        foreach (pl[i])
            send_byte(pl[i]);
        send_byte(t1);
        send_byte(t2);
    endtask

    task automatic random_payload(output byte_t pl [PAYLOAD_LEN]);
        foreach (pl[i])
        begin
            if ($urandom_range(9) == 0)
                pl[i] = $urandom_range(1) ? HDR_FIRST : HDR_SECOND;
            else
                pl[i] = byte_t'($urandom_range(255));
        end
    endtask

    task automatic send_random_traffic(input int n_bytes);
        int    start;
        int    kind;
        int    n_cr;
        byte_t pl [PAYLOAD_LEN];
        byte_t f [4];
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            kind = $urandom_range(99);
            if (kind < 12)
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(byte_t'($urandom_range(255)));
            end
            else
            begin
                n_cr = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3);
                random_payload(pl);
                f = '{HDR_FIRST, HDR_SECOND, HDR_SECOND, HDR_FIRST};
                if (kind < 27)
                    f[$urandom_range(3)] = byte_t'($urandom_range(255));
                send_frame(n_cr, f[0], f[1], pl, f[2], f[3]);
            end
        end
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] a, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (a == ADDR_INVERT)
            invert_cfg = d[0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_frames();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic check_word(input string field, input word_t want, input word_t got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %h, got %h", field, want, got);
        end
    endtask

    // receiver: random stall, or a long hold-off once requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_go)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: z_angle %h", z_angle);
            end
            else
            begin
                want = pending_frames.pop_front();
                check_word("z_angle", want.z_angle, z_angle);
                check_word("x_angle", want.x_angle, x_angle);
                check_word("y_angle", want.y_angle, y_angle);
                check_word("x_position", want.x_position, x_position);
                check_word("y_position", want.y_position, y_position);
                check_word("z_rate", want.z_rate, z_rate);
                check_word("x_position_adjusted", want.x_position_adjusted,
                           x_position_adjusted);
                check_word("y_position_adjusted", want.y_position_adjusted,
                           y_position_adjusted);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[pose_frame_deframer_core] ERROR");
        $finish;
    end

    initial
    begin
        frame_recipe_t r;
        byte_t         pl [PAYLOAD_LEN];
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_valid       <= 1'b0;
        rx_byte        <= '0;
        hold_go        <= 1'b0;
        parse_phase    = PH_HUNT;
        body_idx       = '0;
        foreach (body_buf[i])
            body_buf[i] = '0;
        invert_cfg     = 1'b0;
        use_typed      = 1'b0;
        typed_frame    = '0;
        mismatches     = 0;
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(ADDR_INVERT, 32'h0000_0000);
        // index 4 does not exist, write is dropped
        write_reg(ADDR_UNUSED, 32'h0000_0001);

        for (int n = 0; n < N_DIR; n++)
        begin
            r = dir_rows[n];
            if (r.inv != invert_cfg)
            begin
                drain_frames();
                write_reg(ADDR_INVERT, {31'b0, r.inv});
            end
            foreach (pl[i])
                pl[i] = r.ramp ? byte_t'(r.fill + i) : r.fill;
            use_typed   = r.typed;
            typed_frame = '{r.exp_word, r.exp_word, r.exp_word, r.exp_word,
                            r.exp_word, r.exp_word, r.exp_adj, r.exp_adj};
            send_frame(r.n_cr, HDR_FIRST, r.hdr2, pl, r.trl1, r.trl2);
            use_typed = 1'b0;
        end
        drain_frames();

        for (int p = 0; p < N_TRAFFIC; p++)
        begin
            drain_frames();
            write_reg(ADDR_INVERT, traffic[p].cfg);
            send_idle_pct  = traffic[p].send_pct;
            recv_stall_pct = traffic[p].recv_pct;
            send_random_traffic(230);
        end

        // back-pressure: receiver holds off while well-formed frames keep coming
        drain_frames();
        write_reg(ADDR_INVERT, 32'h0000_0001);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (9)
        begin
            random_payload(pl);
            send_frame(0, HDR_FIRST, HDR_SECOND, pl, HDR_SECOND, HDR_FIRST);
        end
        drain_frames();
        repeat (20)
            @(posedge clk);

        if (mismatches == 0 && pending_frames.size() == 0)
            $display("[pose_frame_deframer_core] OK");
        else
            $display("[pose_frame_deframer_core] ERROR");
        $finish;
    end

endmodule
